@@ hdl/deq_pkg.sv @@
package deq_pkg;

  localparam int OUT_BITS = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } deq_op_t;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctl_t;

endpackage

@@ hdl/deq_cell.sv @@
module deq_cell #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  deq_pkg::cell_ctl_t  ctl,
  input  logic [W-1:0]        push_word,
  input  logic [W-1:0]        left_word,
  input  logic                left_valid,
  input  logic [W-1:0]        right_word,
  input  logic                right_valid,
  output logic [W-1:0]        word,
  output logic                valid
);
  import deq_pkg::*;

  logic [W-1:0] word_next;
  logic         valid_next;

  always_comb begin
    word_next  = word;
    valid_next = valid;
    if (ctl.push_front) begin
      word_next  = left_word;
      valid_next = left_valid;
    end else if (ctl.push_back) begin
      if (!valid && left_valid) begin
        word_next  = push_word;
        valid_next = 1'b1;
      end
    end else if (ctl.pop_front) begin
      word_next  = right_word;
      valid_next = right_valid;
    end else if (ctl.pop_back) begin
      if (valid && !right_valid) begin
        valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

@@ hdl/double_ended_queue_top.sv @@
// Bounded double-ended queue built as a row of storage cells.
// Input channel (in_valid/in_ready) carries operation and value: push front,
// push back, pop front or pop back. Output channel (out_valid/out_ready)
// returns one result per input transaction: popped_value and accepted, plus
// occupancy, front_word, back_word and is_empty describing the queue after
// the operation. A push to a full queue or a pop from an empty one is
// refused (accepted low, popped_value zero) and leaves the queue unchanged.
// Latency: the result is valid the cycle after the input transaction.
// Throughput: one transaction per cycle unless stalled; every cell shifts or
// loads in the same cycle, and the back word is picked from the cell marked last.
// Stall: while a result waits for out_ready, in_ready stays low unless that
// result is taken in the same cycle; the peeks hold since no cell moves.
// Reset: clears all cell valid bits and the count, leaving the queue empty;
// the block takes transactions in the first cycle after reset.
module double_ended_queue_top #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          operation,
  input  logic signed [31:0]                  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  popped_value,
  output logic                                accepted,
  output logic [$clog2(CAPACITY+1)-1:0]       occupancy,
  output logic signed [31:0]                  front_word,
  output logic signed [31:0]                  back_word,
  output logic                                is_empty
);
  import deq_pkg::*;

  localparam int SW = (WORD_BITS < OUT_BITS) ? WORD_BITS : OUT_BITS;
  localparam int SH = OUT_BITS - SW;
  localparam int CW = $clog2(CAPACITY + 1);

  function automatic logic [OUT_BITS-1:0] sext(input logic [SW-1:0] w);
    logic [OUT_BITS-1:0] t;
    t = OUT_BITS'(w) << SH;
    return OUT_BITS'($signed(t) >>> SH);
  endfunction

  logic [SW-1:0] lw [CAPACITY+1];
  logic          lv [CAPACITY+1];
  logic [SW-1:0] rw [CAPACITY+1];
  logic          rv [CAPACITY+1];
  logic [SW-1:0] cw [CAPACITY];
  logic          cv [CAPACITY];

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          fire;
  logic          ok;
  logic          full;
  logic          empty;
  cell_ctl_t     ctl;
  deq_op_t       op;
  logic [SW-1:0] last_word;
  logic [SW-1:0] popped_next;
  logic [SW-1:0] popped;

  assign op       = deq_op_t'(operation);
  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);

  always_comb begin
    ctl         = '0;
    ok          = 1'b0;
    popped_next = '0;
    count_next  = count;
    unique case (op)
      OP_PUSH_FRONT: begin
        ok             = !full;
        ctl.push_front = fire && ok;
      end
      OP_PUSH_BACK: begin
        ok            = !full;
        ctl.push_back = fire && ok;
      end
      OP_POP_FRONT: begin
        ok            = !empty;
        ctl.pop_front = fire && ok;
        popped_next   = cw[0];
      end
      OP_POP_BACK: begin
        ok           = !empty;
        ctl.pop_back = fire && ok;
        popped_next  = last_word;
      end
      default: ok = 1'b0;
    endcase
    if (ctl.push_front || ctl.push_back) begin
      count_next = count + CW'(1);
    end else if (ctl.pop_front || ctl.pop_back) begin
      count_next = count - CW'(1);
    end
  end

  assign lw[0]        = value[SW-1:0];
  assign lv[0]        = 1'b1;
  assign rw[CAPACITY] = '0;
  assign rv[CAPACITY] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign lw[g+1] = cw[g];
      assign lv[g+1] = cv[g];
      assign rw[g]   = cw[g];
      assign rv[g]   = cv[g];
      deq_cell #(.W(SW)) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .push_word   (lw[0]),
        .left_word   (lw[g]),
        .left_valid  (lv[g]),
        .right_word  (rw[g+1]),
        .right_valid (rv[g+1]),
        .word        (cw[g]),
        .valid       (cv[g])
      );
    end
  endgenerate

  always_comb begin
    last_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cv[i] && !rv[i+1]) begin
        last_word = last_word | cw[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted <= ok;
      popped   <= ok ? popped_next : '0;
    end
  end

  assign popped_value = $signed(sext(popped));
  assign occupancy    = count;
  assign is_empty     = empty;
  assign front_word   = empty ? '0 : $signed(sext(cw[0]));
  assign back_word    = empty ? '0 : $signed(sext(last_word));

endmodule
